[rtl/ich_pkg.sv]
// Shared types and constants of the incremental convex hull core.
package ich_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned RIDX_W   = 6;
  localparam int unsigned VCOUNT_W = 7;
  localparam int unsigned MIN_HULL = 3;

  // Command codes of an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_CLEAR,
    OP_RD_REQ,
    OP_RD_CAP,
    OP_V_INIT,
    OP_V_FIRST,
    OP_CAP_B,
    OP_MUL_V,
    OP_V_EVAL,
    OP_DECIDE,
    OP_C_INIT,
    OP_C_STEP,
    OP_C_INS,
    OP_C_DONE,
    OP_L_INIT,
    OP_L_A,
    OP_L_B,
    OP_CAP_C,
    OP_MUL_L,
    OP_L_EVAL,
    OP_EMIT
  } op_e;

  // Command from controller to datapath.
  typedef struct packed {
    op_e  op;
    logic advance;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cnt_lt3;
    logic j_last;
    logic ins_here;
    logic col_zero;
    logic dec_copy;
  } dp_status_t;

endpackage

[rtl/ich_datapath.sv]
// Datapath of the hull core: vertex banks, cross-product unit, scan and copy counters.
module ich_datapath
  import ich_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   ctrl_i,
  output dp_status_t                status_o,
  input  logic signed [FIELD_W-1:0] point_x_i,
  input  logic signed [FIELD_W-1:0] point_y_i,
  input  logic [RIDX_W-1:0]         read_index_i,
  output logic                      accepted_o,
  output logic                      was_inside_o,
  output logic                      overflow_o,
  output logic [VCOUNT_W-1:0]       vertex_count_o,
  output logic signed [FIELD_W-1:0] vertex_x_o,
  output logic signed [FIELD_W-1:0] vertex_y_o
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned NX_W  = CNT_W + 1;
  localparam int unsigned PT_W  = 2 * COORD_BITS;
  localparam int unsigned DIF_W = COORD_BITS + 1;
  localparam int unsigned PRD_W = 2 * DIF_W;
  localparam int unsigned CMP_W = (RIDX_W > CNT_W) ? RIDX_W : CNT_W;

  typedef logic [PT_W-1:0] pt_t;

  // Reduce an index below 2n into the range below n.
  function automatic logic [CNT_W-1:0] wrap_idx(input logic [NX_W-1:0] v,
                                                input logic [CNT_W-1:0] n);
    logic [NX_W-1:0] nn;
    nn = {1'b0, n};
    if (v >= nn) begin
      return CNT_W'(v - nn);
    end
    return CNT_W'(v);
  endfunction

  // Two vertex banks: the active one holds the polygon, the other takes rebuilds.
  pt_t mem0 [MAX_VERTICES];
  pt_t mem1 [MAX_VERTICES];
  pt_t rd0_q, rd1_q, rdata;
  logic             rd_en, wr_en, wr_bank;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  pt_t              wr_data;

  logic bank_q, bank_d;
  logic [CNT_W-1:0] count_q, count_d;

  pt_t p_q, p_d, a_q, a_d, b_q, b_d, c_q, c_d;
  logic [RIDX_W-1:0] ridx_q, ridx_d;
  logic [CNT_W-1:0] j_q, j_d, w_q, w_d;
  logic signed [PRD_W-1:0] l_q, l_d, r_q, r_d;

  logic vis_prev_q, vis_prev_d, vis0_q, vis0_d, s_found_q, s_found_d;
  logic run_open_q, run_open_d, lead_open_q, lead_open_d, any_vis_q, any_vis_d;
  logic ins_q, ins_d;
  logic [CNT_W-1:0] s_q, s_d, run_len_q, run_len_d, lead_len_q, lead_len_d, rem_q, rem_d;

  logic res_acc_q, res_acc_d, res_in_q, res_in_d, res_ovf_q, res_ovf_d;
  logic signed [FIELD_W-1:0] res_vx_q, res_vx_d, res_vy_q, res_vy_d;

  logic out_acc_q, out_acc_d, out_in_q, out_in_d, out_ovf_q, out_ovf_d;
  logic [VCOUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic signed [FIELD_W-1:0] out_vx_q, out_vx_d, out_vy_q, out_vy_d;

  // Cross-product operands and loop helpers.
  pt_t o2;
  logic [COORD_BITS-1:0] ax, ay, bx, by, qx, qy;
  logic signed [DIF_W-1:0] dbx, dby, dqx, dqy;
  logic vis;
  logic [CMP_W-1:0] ridx_ext;
  logic full;
  logic [NX_W-1:0] j_nx;
  logic [NX_W-1:0] off;
  logic skip;
  logic s0, have_run, dec_ovf;
  logic [CNT_W-1:0] dec_s, dec_run;

  assign rdata    = bank_q ? rd1_q : rd0_q;
  assign ridx_ext = CMP_W'(ridx_q);
  assign full     = (count_q >= CNT_W'(MAX_VERTICES));
  assign j_nx     = NX_W'(j_q);
  assign vis      = (l_q < r_q);

  // Operand selection for the shared cross-product unit.
  assign o2  = (ctrl_i.op == OP_MUL_L) ? c_q : p_q;
  assign ax  = a_q[PT_W-1 -: COORD_BITS];
  assign ay  = a_q[COORD_BITS-1:0];
  assign bx  = b_q[PT_W-1 -: COORD_BITS];
  assign by  = b_q[COORD_BITS-1:0];
  assign qx  = o2[PT_W-1 -: COORD_BITS];
  assign qy  = o2[COORD_BITS-1:0];
  assign dbx = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
  assign dby = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
  assign dqx = {qx[COORD_BITS-1], qx} - {ax[COORD_BITS-1], ax};
  assign dqy = {qy[COORD_BITS-1], qy} - {ay[COORD_BITS-1], ay};

  // Cyclic distance of the current vertex from the run start, for the skip test.
  always_comb begin
    if (j_q >= s_q) begin
      off = NX_W'(j_q) - NX_W'(s_q);
    end else begin
      off = NX_W'(j_q) + NX_W'(count_q) - NX_W'(s_q);
    end
    skip = (off != '0) && (off <= NX_W'(rem_q));
  end

  // Resolve the visible run once the edge scan is complete.
  always_comb begin
    s0       = vis0_q && !vis_prev_q;
    have_run = s0 || s_found_q;
    dec_s    = s0 ? '0 : s_q;
    if (s0) begin
      dec_run = lead_len_q;
    end else if (run_open_q) begin
      dec_run = run_len_q + lead_len_q;
    end else begin
      dec_run = run_len_q;
    end
    dec_ovf = have_run && (dec_run == CNT_W'(1)) && full;
  end

  assign status_o.cnt_lt3  = (count_q < CNT_W'(MIN_HULL));
  assign status_o.j_last   = ((j_nx + NX_W'(1)) == NX_W'(count_q));
  assign status_o.ins_here = ins_q && (j_q == s_q);
  assign status_o.col_zero = (l_q == r_q);
  assign status_o.dec_copy = have_run && !dec_ovf;

  // Operation decode.
  always_comb begin
    bank_d = bank_q;       count_d = count_q;
    p_d = p_q;             a_d = a_q;         b_d = b_q;         c_d = c_q;
    ridx_d = ridx_q;       j_d = j_q;         w_d = w_q;
    l_d = l_q;             r_d = r_q;
    vis_prev_d = vis_prev_q; vis0_d = vis0_q; s_found_d = s_found_q;
    run_open_d = run_open_q; lead_open_d = lead_open_q; any_vis_d = any_vis_q;
    ins_d = ins_q;         s_d = s_q;         run_len_d = run_len_q;
    lead_len_d = lead_len_q; rem_d = rem_q;
    res_acc_d = res_acc_q; res_in_d = res_in_q; res_ovf_d = res_ovf_q;
    res_vx_d = res_vx_q;   res_vy_d = res_vy_q;
    out_acc_d = out_acc_q; out_in_d = out_in_q; out_ovf_d = out_ovf_q;
    out_cnt_d = out_cnt_q; out_vx_d = out_vx_q; out_vy_d = out_vy_q;
    rd_en = 1'b0;          rd_addr = '0;
    wr_en = 1'b0;          wr_bank = bank_q;  wr_addr = '0;      wr_data = '0;

    unique case (ctrl_i.op)
      OP_LOAD: begin
        p_d       = {COORD_BITS'($unsigned(point_x_i)), COORD_BITS'($unsigned(point_y_i))};
        ridx_d    = read_index_i;
        res_acc_d = 1'b0;
        res_in_d  = 1'b0;
        res_ovf_d = 1'b0;
        res_vx_d  = '0;
        res_vy_d  = '0;
      end
      OP_APPEND: begin
        if (!full) begin
          wr_en     = 1'b1;
          wr_addr   = count_q[IDX_W-1:0];
          wr_data   = p_q;
          count_d   = count_q + 1'b1;
          res_acc_d = 1'b1;
        end else begin
          res_ovf_d = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      OP_RD_REQ: begin
        rd_en   = 1'b1;
        rd_addr = ridx_ext[IDX_W-1:0];
      end
      OP_RD_CAP: begin
        if (ridx_ext < CMP_W'(count_q)) begin
          res_vx_d = FIELD_W'($signed(rdata[PT_W-1 -: COORD_BITS]));
          res_vy_d = FIELD_W'($signed(rdata[COORD_BITS-1:0]));
        end
      end
      OP_V_INIT: begin
        j_d       = '0;
        rd_en     = 1'b1;
        rd_addr   = '0;
        s_found_d = 1'b0;
        any_vis_d = 1'b0;
        run_open_d = 1'b0;
        run_len_d  = '0;
      end
      OP_V_FIRST, OP_L_A: begin
        a_d     = rdata;
        rd_en   = 1'b1;
        rd_addr = IDX_W'(1);
      end
      OP_CAP_B: begin
        b_d = rdata;
      end
      OP_MUL_V, OP_MUL_L: begin
        l_d = dbx * dqy;
        r_d = dby * dqx;
      end
      OP_V_EVAL: begin
        // Edge j sees the point when the cross product is negative.
        if (j_q == '0) begin
          vis0_d      = vis;
          lead_open_d = vis;
          lead_len_d  = vis ? CNT_W'(1) : '0;
        end else if (lead_open_q) begin
          if (vis) begin
            lead_len_d = lead_len_q + 1'b1;
          end else begin
            lead_open_d = 1'b0;
          end
        end
        if ((j_q != '0) && vis && !vis_prev_q && !s_found_q) begin
          s_found_d  = 1'b1;
          s_d        = j_q;
          run_len_d  = CNT_W'(1);
          run_open_d = 1'b1;
        end else if (s_found_q && run_open_q) begin
          if (vis) begin
            run_len_d = run_len_q + 1'b1;
          end else begin
            run_open_d = 1'b0;
          end
        end
        any_vis_d  = any_vis_q | vis;
        vis_prev_d = vis;
        a_d        = b_q;
        if (!status_o.j_last) begin
          j_d     = j_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = IDX_W'(wrap_idx(j_nx + NX_W'(2), count_q));
        end
      end
      OP_DECIDE: begin
        if (have_run) begin
          if (dec_ovf) begin
            res_ovf_d = 1'b1;
          end else begin
            s_d       = dec_s;
            rem_d     = dec_run - 1'b1;
            ins_d     = 1'b1;
            res_acc_d = 1'b1;
          end
        end else begin
          res_in_d = !any_vis_q;
        end
      end
      OP_C_INIT, OP_L_INIT: begin
        j_d     = '0;
        w_d     = '0;
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_C_STEP: begin
        if (!skip) begin
          wr_en   = 1'b1;
          wr_bank = !bank_q;
          wr_addr = w_q[IDX_W-1:0];
          wr_data = rdata;
          w_d     = w_q + 1'b1;
        end
        if (ctrl_i.advance) begin
          j_d = j_q + 1'b1;
          if (!status_o.j_last) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(j_nx + NX_W'(1));
          end
        end
      end
      OP_C_INS: begin
        wr_en   = 1'b1;
        wr_bank = !bank_q;
        wr_addr = w_q[IDX_W-1:0];
        wr_data = p_q;
        w_d     = w_q + 1'b1;
        j_d     = j_q + 1'b1;
        if (!status_o.j_last) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(j_nx + NX_W'(1));
        end
      end
      OP_C_DONE: begin
        bank_d  = !bank_q;
        count_d = w_q;
      end
      OP_L_B: begin
        b_d     = rdata;
        rd_en   = 1'b1;
        rd_addr = IDX_W'(wrap_idx(NX_W'(2), count_q));
      end
      OP_CAP_C: begin
        c_d = rdata;
      end
      OP_L_EVAL: begin
        // A zero cross product drops the middle vertex through one more copy pass.
        if (status_o.col_zero) begin
          s_d   = j_q;
          rem_d = CNT_W'(1);
          ins_d = 1'b0;
        end else begin
          a_d = b_q;
          b_d = c_q;
          if (!status_o.j_last) begin
            j_d     = j_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = IDX_W'(wrap_idx(j_nx + NX_W'(3), count_q));
          end
        end
      end
      OP_EMIT: begin
        out_acc_d = res_acc_q;
        out_in_d  = res_in_q;
        out_ovf_d = res_ovf_q;
        out_cnt_d = VCOUNT_W'(count_q);
        out_vx_d  = res_vx_q;
        out_vy_d  = res_vy_q;
      end
      default: begin
      end
    endcase
  end

  // Vertex banks with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_bank) begin
      mem0[wr_addr] <= wr_data;
    end
    if (wr_en && wr_bank) begin
      mem1[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd0_q <= mem0[rd_addr];
      rd1_q <= mem1[rd_addr];
    end
  end

  // Polygon control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      count_q <= '0;
    end else begin
      bank_q  <= bank_d;
      count_q <= count_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    p_q <= p_d;   a_q <= a_d;   b_q <= b_d;   c_q <= c_d;
    ridx_q <= ridx_d;  j_q <= j_d;  w_q <= w_d;
    l_q <= l_d;   r_q <= r_d;
    vis_prev_q <= vis_prev_d;  vis0_q <= vis0_d;  s_found_q <= s_found_d;
    run_open_q <= run_open_d;  lead_open_q <= lead_open_d;  any_vis_q <= any_vis_d;
    ins_q <= ins_d;  s_q <= s_d;  run_len_q <= run_len_d;
    lead_len_q <= lead_len_d;  rem_q <= rem_d;
    res_acc_q <= res_acc_d;  res_in_q <= res_in_d;  res_ovf_q <= res_ovf_d;
    res_vx_q <= res_vx_d;    res_vy_q <= res_vy_d;
    out_acc_q <= out_acc_d;  out_in_q <= out_in_d;  out_ovf_q <= out_ovf_d;
    out_cnt_q <= out_cnt_d;  out_vx_q <= out_vx_d;  out_vy_q <= out_vy_d;
  end

  assign accepted_o     = out_acc_q;
  assign was_inside_o   = out_in_q;
  assign overflow_o     = out_ovf_q;
  assign vertex_count_o = out_cnt_q;
  assign vertex_x_o     = out_vx_q;
  assign vertex_y_o     = out_vy_q;

  // The vertex count never passes the store depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count exceeds store depth");

  // A rebuild never writes beyond the store.
  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (ctrl_i.op == OP_C_STEP || ctrl_i.op == OP_C_INS)) |->
      (w_q < CNT_W'(MAX_VERTICES)))
    else $error("rebuild write past store depth");

  // A changed polygon and a refused growth never come together.
  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_EMIT) |-> !(res_acc_q && res_ovf_q))
    else $error("accepted and overflow both set");

endmodule

[rtl/ich_ctrl.sv]
// Controller state machine of the hull core: sequences scans, copies and result handoff.
module ich_ctrl
  import ich_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dp_cmd_t          ctrl_o,
  input  dp_status_t       status_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_APPEND, S_CLEAR, S_RD_REQ, S_RD_CAP,
    S_V_INIT, S_V_FIRST, S_V_CAP, S_V_MUL, S_V_EVAL, S_V_DECIDE,
    S_C_INIT, S_C_STEP, S_C_INS, S_C_DONE,
    S_L_CHECK, S_L_INIT, S_L_A, S_L_B, S_L_CAP, S_L_MUL, S_L_EVAL,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   col_pass_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Operation issued to the datapath in each state.
  always_comb begin
    ctrl_o.op      = OP_NONE;
    ctrl_o.advance = 1'b0;
    unique case (state_q)
      S_IDLE:     ctrl_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_APPEND:   ctrl_o.op = OP_APPEND;
      S_CLEAR:    ctrl_o.op = OP_CLEAR;
      S_RD_REQ:   ctrl_o.op = OP_RD_REQ;
      S_RD_CAP:   ctrl_o.op = OP_RD_CAP;
      S_V_INIT:   ctrl_o.op = OP_V_INIT;
      S_V_FIRST:  ctrl_o.op = OP_V_FIRST;
      S_V_CAP:    ctrl_o.op = OP_CAP_B;
      S_V_MUL:    ctrl_o.op = OP_MUL_V;
      S_V_EVAL:   ctrl_o.op = OP_V_EVAL;
      S_V_DECIDE: ctrl_o.op = OP_DECIDE;
      S_C_INIT:   ctrl_o.op = OP_C_INIT;
      S_C_STEP: begin
        ctrl_o.op      = OP_C_STEP;
        ctrl_o.advance = !status_i.ins_here;
      end
      S_C_INS:    ctrl_o.op = OP_C_INS;
      S_C_DONE:   ctrl_o.op = OP_C_DONE;
      S_L_CHECK:  ctrl_o.op = OP_NONE;
      S_L_INIT:   ctrl_o.op = OP_L_INIT;
      S_L_A:      ctrl_o.op = OP_L_A;
      S_L_B:      ctrl_o.op = OP_L_B;
      S_L_CAP:    ctrl_o.op = OP_CAP_C;
      S_L_MUL:    ctrl_o.op = OP_MUL_L;
      S_L_EVAL:   ctrl_o.op = OP_L_EVAL;
      S_EMIT:     ctrl_o.op = (!out_valid_q || out_ready_i) ? OP_EMIT : OP_NONE;
      default:    ctrl_o.op = OP_NONE;
    endcase
  end

  // State sequencing and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_pass_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The emit state sets the flag itself, so the release is skipped there.
      if (out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (cmd_e'(cmd_i))
              CMD_INSERT: state_q <= status_i.cnt_lt3 ? S_APPEND : S_V_INIT;
              CMD_APPEND: state_q <= S_APPEND;
              CMD_CLEAR:  state_q <= S_CLEAR;
              CMD_READ:   state_q <= S_RD_REQ;
              default:    state_q <= S_IDLE;
            endcase
          end
        end
        S_APPEND, S_CLEAR, S_RD_CAP: state_q <= S_EMIT;
        S_RD_REQ:  state_q <= S_RD_CAP;
        S_V_INIT: begin
          col_pass_q <= 1'b0;
          state_q    <= S_V_FIRST;
        end
        S_V_FIRST: state_q <= S_V_CAP;
        S_V_CAP:   state_q <= S_V_MUL;
        S_V_MUL:   state_q <= S_V_EVAL;
        S_V_EVAL:  state_q <= status_i.j_last ? S_V_DECIDE : S_V_CAP;
        S_V_DECIDE: state_q <= status_i.dec_copy ? S_C_INIT : S_EMIT;
        S_C_INIT:  state_q <= S_C_STEP;
        S_C_STEP: begin
          if (status_i.ins_here) begin
            state_q <= S_C_INS;
          end else if (status_i.j_last) begin
            state_q <= S_C_DONE;
          end
        end
        S_C_INS:   state_q <= status_i.j_last ? S_C_DONE : S_C_STEP;
        S_C_DONE:  state_q <= col_pass_q ? S_EMIT : S_L_CHECK;
        S_L_CHECK: state_q <= status_i.cnt_lt3 ? S_EMIT : S_L_INIT;
        S_L_INIT:  state_q <= S_L_A;
        S_L_A:     state_q <= S_L_B;
        S_L_B:     state_q <= S_L_CAP;
        S_L_CAP:   state_q <= S_L_MUL;
        S_L_MUL:   state_q <= S_L_EVAL;
        S_L_EVAL: begin
          if (status_i.col_zero) begin
            col_pass_q <= 1'b1;
            state_q    <= S_C_INIT;
          end else if (status_i.j_last) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_L_CAP;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A free output slot takes the result at once and frees the input side.
  a_emit_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result handoff stalled with free output slot");

  // A zero cross product in the cleanup scan starts the collinear removal copy.
  a_col_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_L_EVAL && status_i.col_zero) |=> (col_pass_q && state_q == S_C_INIT))
    else $error("collinear removal not started");

  // No new transaction is taken while a command is in progress.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (ctrl_o.op != OP_LOAD))
    else $error("load issued while busy");

endmodule

[rtl/incremental_convex_hull_core.sv]
// Top level of the incremental convex hull core.
//
// Keeps a counter-clockwise polygon of up to MAX_VERTICES vertices in two
// vertex banks and handles one transaction at a time. An insert into a
// polygon of fewer than three vertices is handled as an append. A larger
// insert runs an edge scan and, when the point extends the polygon, a
// rebuild into the other bank, a collinear scan, and one more copy pass
// when a collinear vertex is dropped. Its run time is set by the one shared
// cross-product unit (two multipliers, a register, then a compare) visited
// once per edge, and by the single registered read port of the banks. A
// finished result waits in the output register while the next transaction
// is taken.
module incremental_convex_hull_core
  import ich_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic signed [FIELD_W-1:0] point_x_i,
  input  logic signed [FIELD_W-1:0] point_y_i,
  input  logic [RIDX_W-1:0]         read_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      accepted_o,
  output logic                      was_inside_o,
  output logic                      overflow_o,
  output logic [VCOUNT_W-1:0]       vertex_count_o,
  output logic signed [FIELD_W-1:0] vertex_x_o,
  output logic signed [FIELD_W-1:0] vertex_y_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer.
  ich_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (dp_cmd),
    .status_i    (dp_status)
  );

  // Vertex storage and geometry.
  ich_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (dp_cmd),
    .status_o       (dp_status),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .read_index_i   (read_index_i),
    .accepted_o     (accepted_o),
    .was_inside_o   (was_inside_o),
    .overflow_o     (overflow_o),
    .vertex_count_o (vertex_count_o),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o)
  );

endmodule
